// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the duplicate filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== sv/pidf_pkg.sv =====
// Shared constants, command and status types of the duplicate filter.
package pidf_pkg;
	localparam int RING_SLOTS = 32;
	localparam int MAX_LENGTH = 255;
	localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int IDENT_W = 32;
	localparam int LEN_IN_W = 16;
	localparam int HDR_W = 8;
	localparam int FWD_W = 8;
	localparam int VERDICT_W = 2;
	localparam int S_DATA_W = 48;
	localparam logic [HDR_W-1:0] HEADER_RESET = 8'd16;

	localparam logic [VERDICT_W-1:0] VERDICT_SHORT = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_FORWARD = 2'd2;

	typedef struct packed {
		logic              capture;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              insert;
		logic              emit;
	} pidf_cmd_t;

	typedef struct packed {
		logic too_short;
		logic hit;
	} pidf_sts_t;
endpackage

// ===== sv/pidf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pidf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	clk,
	we,
	waddr,
	wdata,
	re,
	raddr,
	rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	input  logic             clk;
	input  logic             we;
	input  logic [AW-1:0]    waddr;
	input  logic [WIDTH-1:0] wdata;
	input  logic             re;
	input  logic [AW-1:0]    raddr;
	output logic [WIDTH-1:0] rdata;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== sv/pidf_dp.sv =====
// Datapath: header register, item capture, ring storage, compare and result register.
module pidf_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pidf_pkg::HDR_W-1:0]   cfg_wdata,
	input  logic [pidf_pkg::S_DATA_W-1:0] s_tdata,
	input  pidf_pkg::pidf_cmd_t          cmd,
	output pidf_pkg::pidf_sts_t          sts,
	output logic [pidf_pkg::FWD_W-1:0]   m_tdata,
	output logic [pidf_pkg::VERDICT_W-1:0] m_tuser
);
	import pidf_pkg::*;

	logic [HDR_W-1:0]      header_q;
	logic [LEN_IN_W-1:0]   packet_length;
	logic [IDENT_W-1:0]    packet_ident;
	logic [LEN_IN_W-1:0]   len_sat;
	logic [FWD_W-1:0]      len_q;
	logic [IDENT_W-1:0]    ident_q;
	logic                  short_q;
	logic [RING_SLOTS-1:0] valid_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  cmp_s1;
	logic                  vld_s1;
	logic                  hit_q;
	logic [IDENT_W-1:0]    rdata;
	logic                  match;

	assign packet_length = s_tdata[LEN_IN_W-1:0];
	assign packet_ident  = s_tdata[LEN_IN_W +: IDENT_W];
	assign len_sat = (packet_length > LEN_IN_W'(MAX_LENGTH)) ? LEN_IN_W'(MAX_LENGTH)
		: packet_length;

	// A slot never written since reset still holds identifier zero.
	assign match = vld_s1 ? (rdata == ident_q) : (ident_q == '0);

	pidf_ram #(
		.WIDTH(IDENT_W),
		.DEPTH(RING_SLOTS)
	) u_ring (
		.clk  (clk),
		.we   (cmd.insert),
		.waddr(slot_q),
		.wdata(ident_q),
		.re   (cmd.rd_en),
		.raddr(cmd.rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			valid_q  <= '0;
			slot_q   <= '0;
			cmp_s1   <= 1'b0;
			vld_s1   <= 1'b0;
			hit_q    <= 1'b0;
			short_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				header_q <= cfg_wdata;
			end
			cmp_s1 <= cmd.rd_en;
			vld_s1 <= valid_q[cmd.rd_addr];
			if (cmd.capture) begin
				short_q <= !(len_sat > LEN_IN_W'(header_q));
				hit_q   <= 1'b0;
			end else if (cmp_s1 && match) begin
				hit_q <= 1'b1;
			end
			if (cmd.insert) begin
				valid_q[slot_q] <= 1'b1;
				slot_q <= (slot_q == SLOT_W'(RING_SLOTS - 1)) ? '0 : slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			len_q   <= len_sat[FWD_W-1:0];
			ident_q <= packet_ident;
		end
		if (cmd.emit) begin
			priority if (short_q) begin
				m_tuser <= VERDICT_SHORT;
				m_tdata <= '0;
			end else if (hit_q) begin
				m_tuser <= VERDICT_DUPLICATE;
				m_tdata <= '0;
			end else begin
				m_tuser <= VERDICT_FORWARD;
				m_tdata <= len_q;
			end
		end
	end

	assign sts.too_short = short_q;
	assign sts.hit       = hit_q;
endmodule

// ===== sv/pidf_ctrl.sv =====
// Controller: accepts a word, sequences the ring scan and insert, owns the output valid.
`include "assert_macros.svh"
module pidf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  pidf_pkg::pidf_sts_t sts,
	output pidf_pkg::pidf_cmd_t cmd
);
	import pidf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_WRITE,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] cnt_q;
	logic              m_tvalid_q;
	logic              accept;
	logic              out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd         = '0;
		cmd.capture = accept;
		cmd.rd_addr = cnt_q;
		cmd.rd_en   = (state_q == ST_SCAN) && !sts.too_short;
		cmd.insert  = (state_q == ST_WRITE) && !sts.hit;
		cmd.emit    = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// drop straight to the result for a too-short packet
					if (sts.too_short) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == SLOT_W'(RING_SLOTS - 1)) begin
							state_q <= ST_TAIL;
						end
					end
				end
				ST_TAIL: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEVER(a_no_insert_short, cmd.insert && sts.too_short, "insert for short packet")
	`ASSERT_CLK(a_scan_starts_at_zero, accept |=> (state_q == ST_SCAN) && (cnt_q == '0), "scan start")
	`ASSERT_CLK(a_valid_after_done, $rose(m_tvalid_q) |-> $past(state_q == ST_DONE), "stray word")
	`ASSERT_NEVER(a_no_read_outside_scan, cmd.rd_en && (state_q != ST_SCAN), "stray ring read")
endmodule

// ===== sv/packet_id_duplicate_filter.sv =====
// Repeater duplicate filter: one verdict word per packet word.
// A too-short packet goes from the scan state straight to the result; any other packet
// scans the 32-slot ring one slot per cycle through the RAM read port.
// One word in flight: the next word is taken once the result is registered; the
// controller holds in its done state while the output stalls.
// Reset (arst_n low, asynchronous): ring reads as all zero, slot pointer 0, header 16.
module packet_id_duplicate_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pidf_pkg::HDR_W-1:0]      cfg_wdata,   // header_bytes
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pidf_pkg::S_DATA_W-1:0]   s_tdata,     // packet_length[15:0], packet_ident[47:16]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pidf_pkg::FWD_W-1:0]      m_tdata,     // forward_length[7:0]
	output logic [pidf_pkg::VERDICT_W-1:0]  m_tuser      // verdict[1:0]
);
	import pidf_pkg::*;

	pidf_cmd_t cmd;
	pidf_sts_t sts;

	pidf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	pidf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);
endmodule

// ===== dv/packet_id_duplicate_filter_test.sv =====
// Self-checking testbench for the packet id duplicate filter.
`timescale 1ns / 100ps

module packet_id_duplicate_filter_test;
	import pidf_pkg::*;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [FWD_W-1:0]     fwd_len;
	} verdict_t;

	class dup_filter_scoreboard;
		logic [IDENT_W-1:0] seen_ring [RING_SLOTS];
		logic [SLOT_W-1:0]  insert_slot;
		logic [HDR_W-1:0]   header_bytes;
		verdict_t           expected_verdicts [$];
		int                 failures;

		function new();
			foreach (seen_ring[k])
				seen_ring[k] = '0;
			insert_slot = '0;
			header_bytes = HEADER_RESET;
			failures = 0;
		endfunction

		function void note_packet(logic [LEN_IN_W-1:0] len_in, logic [IDENT_W-1:0] ident);
			logic [FWD_W-1:0] len;
			bit               hit;
			verdict_t         e;
			len = (len_in > MAX_LENGTH) ? FWD_W'(MAX_LENGTH) : len_in[FWD_W-1:0];
			hit = 0;
			if (len <= header_bytes) begin
				e = '{VERDICT_SHORT, '0};
			end else begin
				foreach (seen_ring[k])
					if (seen_ring[k] == ident)
						hit = 1;
				if (hit) begin
					e = '{VERDICT_DUPLICATE, '0};
				end else begin
					seen_ring[insert_slot] = ident;
					insert_slot = (insert_slot == SLOT_W'(RING_SLOTS - 1)) ? '0 : insert_slot + 1'b1;
					e = '{VERDICT_FORWARD, len};
				end
			end
			expected_verdicts.push_back(e);
		endfunction

		function void check_verdict(logic [VERDICT_W-1:0] verdict, logic [FWD_W-1:0] fwd_len);
			verdict_t e;
			if (expected_verdicts.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected word: verdict %0d length %0d", verdict, fwd_len);
				return;
			end
			e = expected_verdicts.pop_front();
			if (verdict !== e.verdict || fwd_len !== e.fwd_len) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: verdict %0d length %0d, expected verdict %0d length %0d",
						verdict, fwd_len, e.verdict, e.fwd_len);
			end
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [HDR_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [FWD_W-1:0]     m_tdata;
	logic [VERDICT_W-1:0] m_tuser;

	dup_filter_scoreboard sb = new();
	logic [IDENT_W-1:0]   recent_idents [$];
	bit                   hold_off_req = 0;
	bit                   sender_steady = 0;

	packet_id_duplicate_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_verdict(m_tuser, m_tdata);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [LEN_IN_W-1:0] pick_length(logic [HDR_W-1:0] hdr);
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 50)
			return LEN_IN_W'($urandom_range(0, 300));
		if (r < 65) begin
			// straddle the header boundary
			v = int'(hdr) + int'($urandom_range(0, 2)) - 1;
			if (v < 0)
				v = 0;
			return LEN_IN_W'(v);
		end
		if (r < 80)
			return LEN_IN_W'($urandom());
		if (r < 90)
			return $urandom_range(0, 1) ? LEN_IN_W'(255) : LEN_IN_W'(256);
		return LEN_IN_W'($urandom_range(0, int'(hdr)));
	endfunction

	function automatic logic [IDENT_W-1:0] pick_ident();
		int                 r;
		logic [IDENT_W-1:0] id;
		r = $urandom_range(0, 99);
		if (r < 35 && recent_idents.size() > 0)
			id = recent_idents[$urandom_range(0, recent_idents.size() - 1)];
		else if (r < 42)
			id = '0;
		else if (r < 46)
			id = '1;
		else if (r < 50)
			id = $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31))
				: ~(32'd1 << $urandom_range(0, 31));
		else
			id = $urandom();
		// keep a window wider than the ring so evicted ids come back too
		recent_idents.push_back(id);
		if (recent_idents.size() > 48)
			void'(recent_idents.pop_front());
		return id;
	endfunction

	task automatic send_packet(logic [LEN_IN_W-1:0] len, logic [IDENT_W-1:0] ident);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		if ($urandom_range(0, 49) == 0)
			sender_steady = ~sender_steady;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {ident, len};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_packet(len, ident);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	task automatic write_header(logic [HDR_W-1:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.header_bytes = value;
	endtask

	// receiver: random stalls in stretches, one long hold-off on request
	initial begin
		int stretch;
		int gap;
		bit calm;
		stretch = 0;
		calm = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 0;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				if (stretch == 0) begin
					stretch = $urandom_range(20, 150);
					calm = ($urandom_range(0, 2) == 0);
				end
				stretch--;
				gap = calm ? 0 : pick_gap();
				if (gap == 0) begin
					m_tready <= 1'b1;
					@(posedge clk);
				end else begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	initial begin
		logic [HDR_W-1:0] phase_hdr [8];
		int               p;
		int               i;
		phase_hdr = '{8'd16, 8'd0, 8'd200, 8'd255, 8'($urandom()), 8'd1, 8'd254, 8'($urandom())};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_header(8'd16);
		send_packet(16'd100, 32'h0);           // id zero is already in the cleared ring
		send_packet(16'd16, 32'h1);            // length equal to header
		send_packet(16'd17, 32'h1);            // short one left the ring alone
		send_packet(16'd17, 32'h1);
		send_packet(16'd0, 32'hFFFF_FFFF);
		send_packet(16'hFFFF, 32'hFFFF_FFFF);  // saturate
		send_packet(16'd256, 32'hFFFF_FFFF);
		send_packet(16'd256, 32'h8000_0000);
		send_packet(16'd255, 32'h5555_AAAA);
		send_packet(16'hAAAA, 32'hAAAA_5555);
		send_packet(16'h5555, 32'h0000_0002);
		send_packet(16'd18, 32'h8000_0000);
		write_header(8'd0);
		send_packet(16'd0, 32'h0000_0777);
		send_packet(16'd1, 32'h0000_0777);
		send_packet(16'd1, 32'h0000_0777);
		write_header(8'd255);
		send_packet(16'hFFFF, 32'h1234_5678);
		send_packet(16'd255, 32'h1234_5679);
		send_packet(16'd256, 32'h0);

		for (p = 0; p < 8; p++) begin
			write_header(phase_hdr[p]);
			for (i = 0; i < 150; i++) begin
				if (p == 2 && i == 40)
					hold_off_req = 1;
				send_packet(pick_length(phase_hdr[p]), pick_ident());
			end
		end

		settle();
		repeat (40) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("[packet_id_duplicate_filter] OK");
		else
			$display("[packet_id_duplicate_filter] ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[packet_id_duplicate_filter] ERROR");
		$finish;
	end
endmodule
